>>> hw/rtl/swrs_pkg.sv
// Shared types and constants for the sliding-window resend sender.
`default_nettype none

package swrs_pkg;

   localparam int SEQ_W     = 32;
   localparam int PAYLOAD_W = 11;
   localparam int CHAN_W    = 16;
   localparam int SLOT_W    = 14;
   localparam int HEADER_BYTES = 6;

   // Input word kinds.
   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_NAK  = 2'd1,
      KIND_SEND = 2'd2
   } kind_type;

   // Result kinds.
   typedef enum logic [2:0] {
      RES_NONE   = 3'd0,
      RES_NEW    = 3'd1,
      RES_RESEND = 3'd2,
      RES_FULL   = 3'd3,
      RES_ENDED  = 3'd4
   } result_kind_type;

   // Result fields carried down the slot pipeline.
   typedef struct packed {
      result_kind_type      result_kind;
      logic [SEQ_W-1:0]     sequence_res;
      logic [PAYLOAD_W-1:0] frame_length;
      logic [CHAN_W-1:0]    channel_number;
      logic                 close_channel;
      logic                 notify_ready;
      logic                 queue_overflow;
      logic                 has_slot;
   } rsp_fields_type;

endpackage

`default_nettype wire

>>> hw/rtl/swrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_resend_sender_unit.sv
// Top level of the sliding-window resend sender: state update, resend FIFO and result pipeline.
`default_nettype none

// Sender side of a sliding-window reliable channel. Every input word is an
// ack header, a NAK entry or a send request (req_tuser kind), and every
// accepted word yields exactly one result word on the rsp channel. Acks move
// the confirmed position and may queue a go-back range; NAK entries queue a
// single-sequence range while NAKs are enabled; a send request serves the
// oldest queued resend first, otherwise reports a full window, issues a new
// frame or reports that the source has ended. The block accepts one word
// per clock cycle unless the result path backs up. All state is updated in
// the cycle a word is accepted; the result then passes three more register
// stages that reduce the sequence number modulo WINDOW (a reciprocal
// multiply, a multiply back and one corrective subtract). Each stage holds
// its word until the next one is free, so the req side stalls once every
// stage holds a word and a result waits. The resend FIFO keeps its head
// range in registers and the rest in a RAM whose read port always fetches
// the entry behind the head; its contents need no clearing after reset.
// dest_channel is written through csr_wr_en and csr_wr_data and must only
// change while no word is in flight.
module sliding_window_resend_sender_unit #(
   parameter int WINDOW      = 16384,
   parameter int RANGE_DEPTH = 64,
   parameter int MAX_FRAME   = 1444
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // ack_position [31:0], nak_position [63:32], payload_length [74:64], zeros above.
   input  wire logic [79:0] req_tdata,
   // kind [1:0], rewind [2].
   input  wire logic [2:0]  req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // sequence_res [31:0], slot [45:32], frame_length [56:46],
   // channel_number [72:57], close_channel [73], notify_ready [74],
   // queue_overflow [75], zeros above.
   output logic      [79:0] rsp_tdata,
   // result_kind [2:0].
   output logic      [2:0]  rsp_tuser,
   // Configuration port for dest_channel.
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   import swrs_pkg::*;

   localparam int IDX_W = $clog2(RANGE_DEPTH);
   localparam int CNT_W = $clog2(RANGE_DEPTH + 1);
   localparam int MAX_PAYLOAD = MAX_FRAME - HEADER_BYTES;
   localparam int LEN_W = 14;
   localparam logic [SEQ_W-1:0] WINDOW_C = SEQ_W'(WINDOW);
   // floor(2^32 / WINDOW); the quotient estimate is low by at most one.
   localparam logic [SEQ_W-1:0] RECIP = SEQ_W'(64'h1_0000_0000 / WINDOW);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(RANGE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // Request fields.
   logic [SEQ_W-1:0]     ack_position;
   logic [SEQ_W-1:0]     nak_position;
   logic [PAYLOAD_W-1:0] payload_length;
   logic                 rewind;
   kind_type             kind;

   assign ack_position   = req_tdata[31:0];
   assign nak_position   = req_tdata[63:32];
   assign payload_length = req_tdata[74:64];
   assign kind           = kind_type'(req_tuser[1:0]);
   assign rewind         = req_tuser[2];

   // Sender state.
   logic [SEQ_W-1:0]  next_to_send_ff, next_to_send_in;
   logic [SEQ_W-1:0]  confirmed_upto_ff, confirmed_upto_in;
   logic              source_ended_ff, source_ended_in;
   logic              naks_accepted_ff, naks_accepted_in;
   logic [IDX_W-1:0]  range_head_ff, range_head_in;
   logic [IDX_W-1:0]  range_tail_ff, range_tail_in;
   logic [CNT_W-1:0]  range_count_ff, range_count_in;
   logic [SEQ_W-1:0]  head_first_ff, head_first_in;
   logic [SEQ_W-1:0]  head_last_ff, head_last_in;
   logic [CHAN_W-1:0] dest_channel_ff;

   // Read bypass for an entry written in the same cycle it was read.
   logic                 bypass_ff, bypass_in;
   logic [2*SEQ_W-1:0]   bypass_data_ff;
   logic [2*SEQ_W-1:0]   ram_rd_data;
   logic [2*SEQ_W-1:0]   next_entry;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic                 ram_wr_en;
   logic [2*SEQ_W-1:0]   ram_wr_data;

   logic                 push_en;
   logic [SEQ_W-1:0]     push_first;
   logic [SEQ_W-1:0]     push_last;
   logic [LEN_W-1:0]     payload_sat;

   // Pipeline handshake.
   logic req_acc;
   logic ready0, ready1, ready2, ready3;
   logic valid0_ff, valid1_ff, valid2_ff, valid3_ff;

   rsp_fields_type res0_in;
   rsp_fields_type res0_ff, res1_ff, res2_ff, res3_ff;
   logic [SEQ_W-1:0]  quot1_ff;
   logic [SEQ_W-1:0]  qw2_ff;
   logic [SLOT_W-1:0] slot3_ff;
   logic [2*SEQ_W-1:0] recip_prod;
   logic [SEQ_W+SEQ_W-1:0] back_prod;
   logic [SEQ_W-1:0]  rem_raw;
   logic [SEQ_W-1:0]  rem_fix;

   assign ready3 = !valid3_ff || rsp_tready;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;
   assign ready0 = !valid0_ff || ready1;
   assign req_tready = ready0;
   assign req_acc = req_tvalid && ready0;

   assign next_entry = bypass_ff ? bypass_data_ff : ram_rd_data;

   // The ceiling makes payload lengths beyond the frame limit saturate.
   assign payload_sat = ({3'b000, payload_length} > LEN_W'(MAX_PAYLOAD)) ?
                        LEN_W'(MAX_PAYLOAD) : {3'b000, payload_length};

   always_comb begin
      next_to_send_in   = next_to_send_ff;
      confirmed_upto_in = confirmed_upto_ff;
      source_ended_in   = source_ended_ff;
      naks_accepted_in  = naks_accepted_ff;
      range_head_in     = range_head_ff;
      range_tail_in     = range_tail_ff;
      range_count_in    = range_count_ff;
      head_first_in     = head_first_ff;
      head_last_in      = head_last_ff;
      res0_in           = '0;
      push_en           = 1'b0;
      push_first        = ack_position;
      push_last         = next_to_send_ff - 1'b1;
      ram_wr_en         = 1'b0;

      if (req_acc) begin
         case (kind)
            KIND_ACK: begin
               if (ack_position < confirmed_upto_ff) begin
                  // A stale ack only closes the NAK gate.
                  naks_accepted_in = 1'b0;
               end else if (rewind) begin
                  push_en = (ack_position < next_to_send_ff);
                  confirmed_upto_in = ack_position;
                  naks_accepted_in  = 1'b0;
                  res0_in.close_channel = source_ended_ff;
               end else if (ack_position > confirmed_upto_ff) begin
                  confirmed_upto_in = ack_position;
                  naks_accepted_in  = 1'b1;
                  res0_in.notify_ready = 1'b1;
               end else begin
                  naks_accepted_in = (range_count_ff == '0);
                  res0_in.notify_ready = 1'b1;
               end
            end
            KIND_NAK: begin
               push_en    = naks_accepted_ff;
               push_first = nak_position;
               push_last  = nak_position;
            end
            KIND_SEND: begin
               if (range_count_ff != '0) begin
                  res0_in.result_kind    = RES_RESEND;
                  res0_in.sequence_res   = head_first_ff;
                  res0_in.channel_number = dest_channel_ff;
                  res0_in.has_slot       = 1'b1;
                  if (head_first_ff == head_last_ff) begin
                     // Head range used up; the entry behind it moves up.
                     range_head_in  = idx_next(range_head_ff);
                     range_count_in = range_count_ff - 1'b1;
                     head_first_in  = next_entry[SEQ_W-1:0];
                     head_last_in   = next_entry[2*SEQ_W-1:SEQ_W];
                  end else begin
                     head_first_in = head_first_ff + 1'b1;
                  end
               end else if ((next_to_send_ff - confirmed_upto_ff) >= WINDOW_C) begin
                  res0_in.result_kind = RES_FULL;
               end else if (payload_length == '0) begin
                  source_ended_in     = 1'b1;
                  res0_in.result_kind = RES_ENDED;
               end else begin
                  res0_in.result_kind    = RES_NEW;
                  res0_in.sequence_res   = next_to_send_ff;
                  res0_in.frame_length   = PAYLOAD_W'(payload_sat + LEN_W'(HEADER_BYTES));
                  res0_in.channel_number = dest_channel_ff;
                  res0_in.has_slot       = 1'b1;
                  next_to_send_in        = next_to_send_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // Push and pop never happen for the same word.
      if (push_en) begin
         if (range_count_ff == CNT_W'(RANGE_DEPTH)) begin
            res0_in.queue_overflow = 1'b1;
         end else begin
            ram_wr_en      = 1'b1;
            range_tail_in  = idx_next(range_tail_ff);
            range_count_in = range_count_ff + 1'b1;
            if (range_count_ff == '0) begin
               head_first_in = push_first;
               head_last_in  = push_last;
            end
         end
      end
   end

   assign ram_wr_data = {push_last, push_first};
   assign ram_rd_addr = idx_next(range_head_in);
   assign bypass_in   = ram_wr_en && (range_tail_ff == ram_rd_addr);

   swrs_ram #(
      .WIDTH (2 * SEQ_W),
      .DEPTH (RANGE_DEPTH)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (range_tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_to_send_ff   <= '0;
         confirmed_upto_ff <= '0;
         source_ended_ff   <= 1'b0;
         naks_accepted_ff  <= 1'b0;
         range_head_ff     <= '0;
         range_tail_ff     <= '0;
         range_count_ff    <= '0;
         dest_channel_ff   <= '0;
         bypass_ff         <= 1'b0;
      end else begin
         next_to_send_ff   <= next_to_send_in;
         confirmed_upto_ff <= confirmed_upto_in;
         source_ended_ff   <= source_ended_in;
         naks_accepted_ff  <= naks_accepted_in;
         range_head_ff     <= range_head_in;
         range_tail_ff     <= range_tail_in;
         range_count_ff    <= range_count_in;
         bypass_ff         <= bypass_in;
         if (csr_wr_en) begin
            dest_channel_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_first_ff  <= head_first_in;
      head_last_ff   <= head_last_in;
      bypass_data_ff <= ram_wr_data;
   end

   // Slot pipeline: sequence modulo WINDOW over three stages.
   assign recip_prod = res0_ff.sequence_res * RECIP;
   assign back_prod  = quot1_ff * WINDOW_C;
   assign rem_raw    = res2_ff.sequence_res - qw2_ff;
   assign rem_fix    = (rem_raw >= WINDOW_C) ? rem_raw - WINDOW_C : rem_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready0) begin
            valid0_ff <= req_tvalid;
         end
         if (ready1) begin
            valid1_ff <= valid0_ff;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready0) begin
         res0_ff <= res0_in;
      end
      if (ready1) begin
         res1_ff  <= res0_ff;
         quot1_ff <= recip_prod[2*SEQ_W-1:SEQ_W];
      end
      if (ready2) begin
         res2_ff <= res1_ff;
         qw2_ff  <= back_prod[SEQ_W-1:0];
      end
      if (ready3) begin
         res3_ff  <= res2_ff;
         slot3_ff <= res2_ff.has_slot ? rem_fix[SLOT_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = valid3_ff;
   assign rsp_tuser  = res3_ff.result_kind;
   assign rsp_tdata  = {4'b0000,
                        res3_ff.queue_overflow,
                        res3_ff.notify_ready,
                        res3_ff.close_channel,
                        res3_ff.channel_number,
                        res3_ff.frame_length,
                        slot3_ff,
                        res3_ff.sequence_res};

endmodule

`default_nettype wire

>>> bench/sliding_window_resend_sender_unit_tb.sv
// Self-checking testbench for the sliding-window resend sender unit.
`default_nettype none

module sliding_window_resend_sender_unit_tb;
   import swrs_pkg::*;

   localparam int WINDOW      = 16384;
   localparam int RANGE_DEPTH = 64;
   localparam int MAX_FRAME   = 1444;
   localparam int MAX_BODY    = MAX_FRAME - HEADER_BYTES;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // One predicted result word, field for field as it leaves the block.
   typedef struct packed {
      result_kind_type      kind;
      logic [SEQ_W-1:0]     seq;
      logic [SLOT_W-1:0]    slot;
      logic [PAYLOAD_W-1:0] flen;
      logic [CHAN_W-1:0]    chan;
      logic                 close_ch;
      logic                 notify;
      logic                 overflow;
   } frame_result_type;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      RX_STEADY   = 2'd0,
      RX_COIN     = 2'd1,
      RX_PERIODIC = 2'd2,
      RX_SPARSE   = 2'd3
   } rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // Predictor state, updated as each word is accepted.
   logic [CHAN_W-1:0] chan_setting;
   logic [31:0]       sent_next;
   logic [31:0]       confirmed_pos;
   logic              ended_flag;
   logic              naks_on;
   logic [63:0]       resend_q[$];   // {last, first} per range
   frame_result_type  due_results[$];

   int          live_words;
   int          fail_count;
   int          burst_left;
   logic        sender_gaps;

   rx_mode_type rx_mode;
   int          rx_mode_left;
   int          rx_phase;
   int          hold_left;
   logic        hold_start;

   sliding_window_resend_sender_unit #(
      .WINDOW      (WINDOW),
      .RANGE_DEPTH (RANGE_DEPTH),
      .MAX_FRAME   (MAX_FRAME)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Queues a resend range unless the range FIFO is full; returns the overflow flag.
   function automatic logic queue_range(input logic [31:0] first, input logic [31:0] last);
      if (resend_q.size() >= RANGE_DEPTH) return 1'b1;
      resend_q.push_back({last, first});
      return 1'b0;
   endfunction

   // Works out the result of one accepted word and advances the sender state.
   function automatic frame_result_type frame_decision(input logic [1:0] kind,
                                                       input logic [31:0] ack,
                                                       input logic rewind,
                                                       input logic [31:0] nak,
                                                       input logic [10:0] payload);
      frame_result_type r;
      logic [31:0] first_seq;
      logic [31:0] distance;
      logic [10:0] body;
      r = '0;
      if (kind != KIND_UNUSED && !(kind == KIND_NAK && !naks_on)) live_words++;
      case (kind)
         KIND_ACK: begin
            if (ack < confirmed_pos) begin
               naks_on = 1'b0;
            end else if (rewind) begin
               // Go-back form: everything from the ack up to the newest frame is resent.
               if (ack < sent_next) r.overflow = queue_range(ack, sent_next - 32'd1);
               confirmed_pos = ack;
               naks_on = 1'b0;
               r.close_ch = ended_flag;
            end else if (ack > confirmed_pos) begin
               confirmed_pos = ack;
               naks_on = 1'b1;
               r.notify = 1'b1;
            end else begin
               naks_on = (resend_q.size() == 0);
               r.notify = 1'b1;
            end
         end
         KIND_NAK: begin
            if (naks_on) r.overflow = queue_range(nak, nak);
         end
         KIND_SEND: begin
            distance = sent_next - confirmed_pos;
            if (resend_q.size() != 0) begin
               first_seq = resend_q[0][31:0];
               if (first_seq == resend_q[0][63:32]) resend_q.delete(0);
               else resend_q[0] = {resend_q[0][63:32], first_seq + 32'd1};
               r.kind = RES_RESEND;
               r.seq  = first_seq;
               r.slot = SLOT_W'(first_seq % WINDOW);
               r.chan = chan_setting;
            end else if (distance >= WINDOW) begin
               r.kind = RES_FULL;
            end else if (payload == 0) begin
               ended_flag = 1'b1;
               r.kind = RES_ENDED;
            end else begin
               body = (payload > MAX_BODY) ? 11'(MAX_BODY) : payload;
               r.kind = RES_NEW;
               r.seq  = sent_next;
               r.slot = SLOT_W'(sent_next % WINDOW);
               r.flen = PAYLOAD_W'(body + HEADER_BYTES);
               r.chan = chan_setting;
               sent_next = sent_next + 32'd1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Tracks accepted words on both channels and the register writes.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset) begin
         if (csr_wr_en) chan_setting = csr_wr_data;
         if (req_tvalid && req_tready)
            due_results.push_back(frame_decision(req_tuser[1:0], req_tdata[31:0], req_tuser[2],
                                                 req_tdata[63:32], req_tdata[74:64]));
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result word with nothing pending, actual kind %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("sequence_res", want.seq, rsp_tdata[31:0]);
               check_field("slot", 32'(want.slot), 32'(rsp_tdata[45:32]));
               check_field("frame_length", 32'(want.flen), 32'(rsp_tdata[56:46]));
               check_field("channel_number", 32'(want.chan), 32'(rsp_tdata[72:57]));
               check_field("close_channel", 32'(want.close_ch), 32'(rsp_tdata[73]));
               check_field("notify_ready", 32'(want.notify), 32'(rsp_tdata[74]));
               check_field("queue_overflow", 32'(want.overflow), 32'(rsp_tdata[75]));
               check_field("rsp_tdata padding", 32'd0, 32'(rsp_tdata[79:76]));
            end
         end
      end
   end

   // Receiver: changes its stall pattern now and then, and on request holds
   // off completely for a long count of cycles so the block backs up.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 160);
         end
         rx_mode_left--;
         rx_phase++;
         case (rx_mode)
            RX_STEADY:   rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_tready <= (rx_phase % 5) < 3;
            default:     rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Offers one word and returns at the falling edge after it was taken.
   // The valid stays high so back-to-back words need no bubble.
   task automatic send_word(input logic [1:0] kind, input logic [31:0] ack,
                            input logic rewind, input logic [31:0] nak,
                            input logic [10:0] payload);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= {rewind, kind};
      req_tdata  <= {5'd0, payload, nak, ack};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Unused fields of each word carry random bits.
   task automatic send_ack(input logic [31:0] ack, input logic rewind);
      send_word(KIND_ACK, ack, rewind, $urandom, 11'($urandom_range(0, 2047)));
   endtask

   task automatic send_nak(input logic [31:0] position);
      send_word(KIND_NAK, $urandom, 1'($urandom_range(0, 1)), position,
                11'($urandom_range(0, 2047)));
   endtask

   task automatic send_request(input logic [10:0] payload);
      send_word(KIND_SEND, $urandom, 1'($urandom_range(0, 1)), $urandom, payload);
   endtask

   // Drops valid and waits until every predicted result has been checked.
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
   endtask

   // Register writes happen only with nothing in flight.
   task automatic set_channel(input logic [15:0] value);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Serves send requests until the resend FIFO is empty.
   task automatic flush_resends();
      while (resend_q.size() != 0) send_request(11'($urandom_range(1, MAX_BODY)));
   endtask

   function automatic logic [10:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return 11'd0;
      if (roll < 8) return 11'($urandom_range(MAX_BODY + 1, 2047));
      if (roll < 20) return 11'($urandom_range(1024, MAX_BODY));
      return 11'($urandom_range(1, 1023));
   endfunction

   // Mostly positions inside the unconfirmed span, otherwise anywhere.
   function automatic logic [31:0] pick_nak();
      logic [31:0] span;
      span = sent_next - confirmed_pos;
      if ($urandom_range(0, 99) < 60 && span != 0)
         return confirmed_pos + $urandom_range(0, span - 1);
      return $urandom;
   endfunction

   task automatic test_directed_cases();
      sender_gaps = 1'b0;
      send_request(11'd1);
      send_request(11'(MAX_BODY));
      send_request(11'h7FF);              // oversized payload saturates
      send_request(11'd1024);
      send_word(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 11'h7FF);
      send_ack(32'd2, 1'b0);              // newer ack enables NAKs
      send_nak(32'hFFFF_FFFF);
      send_nak(32'd0);
      send_ack(32'd2, 1'b0);              // equal ack with a queue disables NAKs
      send_nak(32'd5);                    // ignored
      send_request(11'd1);
      send_request(11'd1);
      send_ack(32'd1, 1'b0);              // stale
      send_ack(32'd2, 1'b0);              // equal ack, empty queue
      send_ack(32'd2, 1'b1);              // rewind queues the unconfirmed span
      send_request(11'd1);
      send_request(11'd1);
      send_request(11'd0);                // source ended
      send_ack(sent_next, 1'b1);          // rewind at the head: close only
      send_request(11'd700);              // frames still go out after the end
      send_ack(sent_next, 1'b0);
   endtask

   // Random traffic in phases, each under its own channel setting.
   task automatic test_random_traffic();
      logic [15:0] value;
      logic [31:0] span;
      logic [1:0]  kind;
      int          stop_at;
      int          pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       value = 16'hFFFF;
            1:       value = 16'h0000;
            2:       value = 16'h5AA5;
            3:       value = 16'hA55A;
            default: value = 16'($urandom_range(0, 65535));
         endcase
         set_channel(value);
         sender_gaps = (phase % 2 == 0);
         stop_at = live_words + 290;
         while (live_words < stop_at) begin
            pick = $urandom_range(0, 99);
            span = sent_next - confirmed_pos;
            if (pick < 40) begin
               // Progress ack, a run of NAK entries, then requests.
               send_ack(confirmed_pos + $urandom_range(0, span), 1'b0);
               repeat ($urandom_range(0, 6)) send_nak(pick_nak());
               repeat ($urandom_range(1, 6)) send_request(pick_payload());
            end else if (pick < 60) begin
               repeat ($urandom_range(1, 10)) send_request(pick_payload());
            end else if (pick < 78) begin
               // Go-back ack a short way behind the newest frame.
               send_ack(sent_next - ((span > 40) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, span)), 1'b1);
               repeat ($urandom_range(1, 8)) send_request(pick_payload());
            end else if (pick < 90) begin
               // Broken sequence: NAK entries after an ack that disables them.
               if (confirmed_pos != 0 && $urandom_range(0, 1)) send_ack(confirmed_pos - 1, 1'b0);
               else send_ack(confirmed_pos, 1'b1);
               repeat ($urandom_range(1, 4)) send_nak(pick_nak());
            end else begin
               // Noise. Acks never move the confirmed position forward here,
               // since an ack past the newest frame closes the window for good.
               kind = 2'($urandom_range(0, 3));
               if (kind == KIND_ACK)
                  send_word(kind, $urandom_range(0, confirmed_pos), 1'b0, $urandom,
                            11'($urandom_range(0, 2047)));
               else
                  send_word(kind, $urandom, 1'($urandom_range(0, 1)), pick_nak(),
                            pick_payload());
            end
         end
      end
   endtask

   // Fills the range FIFO past its depth while the receiver holds off, so
   // the result path backs up and the request side stalls.
   task automatic test_resend_overflow_with_stall();
      sender_gaps = 1'b0;
      flush_resends();
      send_request(11'($urandom_range(1, MAX_BODY)));
      send_ack(sent_next, 1'b0);
      hold_start = 1'b1;
      repeat (RANGE_DEPTH + 8) send_nak($urandom);
      wait_all_results();
      repeat (RANGE_DEPTH + 1) send_request(pick_payload());
   endtask

   // An ack past the newest frame leaves the window reading full.
   task automatic test_window_full();
      sender_gaps = 1'b1;
      flush_resends();
      send_ack(sent_next + 32'd100, 1'b0);
      repeat (3) send_request(pick_payload());
      repeat (3) send_nak($urandom);
      repeat (4) send_request(pick_payload());
      send_ack(32'hFFFF_FFFF, 1'b0);
      send_request(11'd0);
      send_request(11'(MAX_BODY));
      send_ack(32'hFFFF_FFFF, 1'b1);
      send_ack(32'd0, 1'b0);
      send_request(11'd1);
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      chan_setting  = '0;
      sent_next     = '0;
      confirmed_pos = '0;
      ended_flag    = 1'b0;
      naks_on       = 1'b0;
      live_words    = 0;
      fail_count    = 0;
      burst_left    = 0;
      sender_gaps   = 1'b0;
      rx_mode       = RX_STEADY;
      rx_mode_left  = 0;
      rx_phase      = 0;
      hold_left     = 0;
      hold_start    = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic();
      test_resend_overflow_with_stall();
      test_window_full();

      wait_all_results();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
